// ===== design/s5hs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s5hs_pkg
// Shared types and sizes of the SOCKS5 client handshake block.
// ----------------------------------------------------------------------------
package s5hs_pkg;

	localparam int MAX_STRING  = 256;
	localparam int STORE_AW    = $clog2(MAX_STRING);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD_HOST,
		OP_LOAD_USER,
		OP_LOAD_PASS,
		OP_START,
		OP_RX,
		OP_PULL
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] index;
		logic [7:0] value;
	} cmd_t;

endpackage

// ===== design/s5hs_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s5hs_in_if
// Input channel: one command item per transaction.
// ----------------------------------------------------------------------------
interface s5hs_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic [7:0] index;
	logic [7:0] value;

	modport source (output valid, output mode, output index, output value, input ready);
	modport sink (input valid, input mode, input index, input value, output ready);
endinterface

// ===== design/s5hs_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s5hs_out_if
// Result channel: transmit byte, status and reply code per transaction.
// ----------------------------------------------------------------------------
interface s5hs_out_if;
	logic       valid;
	logic       ready;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       tx_last;
	logic [2:0] status;
	logic       reply_valid;
	logic [7:0] reply_code;

	modport source (
		output valid, output tx_valid, output tx_byte, output tx_last,
		output status, output reply_valid, output reply_code, input ready
	);
	modport sink (
		input valid, input tx_valid, input tx_byte, input tx_last,
		input status, input reply_valid, input reply_code, output ready
	);
endinterface

// ===== design/s5hs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s5hs_front
// Accepts input transactions, decodes the mode into an operation and
// buffers the commands in a short queue ahead of the execute stage.
// ----------------------------------------------------------------------------
module s5hs_front
	import s5hs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	s5hs_in_if.sink   req,
	output logic      q_valid,
	input  logic      q_ready,
	output cmd_t      q_cmd
);

	localparam logic [2:0] MODE_LOAD_HOST = 3'd0;
	localparam logic [2:0] MODE_LOAD_USER = 3'd1;
	localparam logic [2:0] MODE_LOAD_PASS = 3'd2;
	localparam logic [2:0] MODE_START     = 3'd3;
	localparam logic [2:0] MODE_RX        = 3'd4;
	localparam logic [2:0] MODE_PULL      = 3'd5;

	cmd_t              dec_cmd;
	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	always_comb begin
		dec_cmd.index = req.index;
		dec_cmd.value = req.value;
		unique case (req.mode)
			MODE_LOAD_HOST: dec_cmd.op = OP_LOAD_HOST;
			MODE_LOAD_USER: dec_cmd.op = OP_LOAD_USER;
			MODE_LOAD_PASS: dec_cmd.op = OP_LOAD_PASS;
			MODE_START:     dec_cmd.op = OP_START;
			MODE_RX:        dec_cmd.op = OP_RX;
			MODE_PULL:      dec_cmd.op = OP_PULL;
			default:        dec_cmd.op = OP_NOP;
		endcase
	end

	assign req.ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push      = req.valid & req.ready;
	assign q_valid   = (count_q != '0);
	assign pop       = q_valid & q_ready;
	assign q_cmd     = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) wr_ptr_q <= '0;
				else wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				if (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) rd_ptr_q <= '0;
				else rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= dec_cmd;
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue fill count above depth");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == QCNT_W'($past(count_q) + 1'b1))
		else $error("push without pop did not raise the fill count");
`endif

endmodule

// ===== design/s5hs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s5hs_back
// Execute stage: handshake state machine, string stores, configuration
// registers and the result register toward the output channel.
// ----------------------------------------------------------------------------
module s5hs_back
	import s5hs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  cmd_t                  q_cmd,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	s5hs_out_if.source            rsp
);

	localparam logic [CFG_IDX_W-1:0] CFG_HOST_LENGTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_TGT_PORT    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_USE_AUTH    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_USER_LENGTH = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] CFG_PASS_LENGTH = CFG_IDX_W'(4);

	localparam logic [2:0] STATUS_BUSY      = 3'd0;
	localparam logic [2:0] STATUS_CONNECTED = 3'd1;
	localparam logic [2:0] STATUS_BAD_HOST  = 3'd2;
	localparam logic [2:0] STATUS_PROTO     = 3'd3;
	localparam logic [2:0] STATUS_AUTH      = 3'd4;
	localparam logic [2:0] STATUS_REFUSED   = 3'd5;

	localparam logic [7:0] SOCKS_VER       = 8'd5;
	localparam logic [7:0] AUTH_VER        = 8'd1;
	localparam logic [7:0] METHOD_NONE     = 8'd0;
	localparam logic [7:0] METHOD_USERPASS = 8'd2;
	localparam logic [7:0] CMD_CONNECT     = 8'd1;
	localparam logic [7:0] ATYP_IPV4       = 8'd1;
	localparam logic [7:0] ATYP_DOMAIN     = 8'd3;
	localparam logic [7:0] ATYP_IPV6       = 8'd4;
	localparam logic [7:0] REP_OK          = 8'd0;
	localparam logic [8:0] IPV4_BOUND      = 9'd6;
	localparam logic [8:0] IPV6_BOUND      = 9'd18;

	typedef enum logic [3:0] {
		PH_IDLE, PH_GREET_TX, PH_GREET_RX, PH_AUTH_TX, PH_AUTH_RX, PH_REQ_TX,
		PH_REP_RX, PH_REP_LEN, PH_BOUND_RX, PH_DONE, PH_ERR_HOST, PH_ERR_PROTO,
		PH_ERR_AUTH, PH_ERR_REFUSED
	} phase_t;

	typedef enum logic [1:0] {SEL_CONST, SEL_HOST, SEL_USER, SEL_PASS} sel_t;

	// configuration
	logic [7:0]  host_len_q;
	logic [15:0] tgt_port_q;
	logic        use_auth_q;
	logic [7:0]  user_len_q;
	logic [7:0]  pass_len_q;

	// handshake state
	phase_t      phase_q;
	logic [9:0]  tx_pos_q;
	logic [1:0]  rx_pos_q;
	logic [8:0]  bound_q;
	logic [7:0]  reply_byte_q;
	logic        reply_seen_q;

	phase_t      phase_d;
	logic [9:0]  tx_pos_d;
	logic [1:0]  rx_pos_d;
	logic [8:0]  bound_d;
	logic [7:0]  reply_byte_d;
	logic        reply_seen_d;

	logic        fire;
	logic        txv;
	logic        txl;
	logic [7:0]  const_byte;
	sel_t        sel;
	logic [7:0]  rd_idx;
	logic [9:0]  msg_len;
	logic [9:0]  user_end;
	logic [9:0]  auth_len;
	logic [9:0]  host_end;
	logic [7:0]  user_idx;
	logic [7:0]  pass_idx;
	logic [7:0]  host_idx;
	logic [2:0]  status_d;
	logic        wr_ok;

	// result register
	logic        out_valid_s2;
	logic        tx_valid_s2;
	logic        tx_last_s2;
	logic [7:0]  const_s2;
	sel_t        sel_s2;
	logic [2:0]  status_s2;
	logic        reply_valid_s2;
	logic [7:0]  reply_code_s2;
	logic [7:0]  host_rd_s2;
	logic [7:0]  user_rd_s2;
	logic [7:0]  pass_rd_s2;

	logic [7:0]  host_mem [MAX_STRING];
	logic [7:0]  user_mem [MAX_STRING];
	logic [7:0]  pass_mem [MAX_STRING];

	function automatic logic idx_in_range(input logic [7:0] idx);
		return {1'b0, idx} < 9'(MAX_STRING);
	endfunction

	assign q_ready = !out_valid_s2 || rsp.ready;
	assign fire    = q_valid && q_ready;
	assign wr_ok   = idx_in_range(q_cmd.index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_len_q  <= '0;
			tgt_port_q  <= '0;
			use_auth_q  <= 1'b0;
			user_len_q  <= '0;
			pass_len_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HOST_LENGTH: host_len_q  <= cfg_data[7:0];
				CFG_TGT_PORT:    tgt_port_q  <= cfg_data[15:0];
				CFG_USE_AUTH:    use_auth_q  <= cfg_data[0];
				CFG_USER_LENGTH: user_len_q  <= cfg_data[7:0];
				CFG_PASS_LENGTH: pass_len_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// message layout boundaries
	assign user_end = 10'd2 + 10'(user_len_q);
	assign auth_len = 10'd3 + 10'(user_len_q) + 10'(pass_len_q);
	assign host_end = 10'd5 + 10'(host_len_q);
	assign user_idx = 8'(tx_pos_q - 10'd2);
	assign pass_idx = 8'(tx_pos_q - 10'd3 - 10'(user_len_q));
	assign host_idx = 8'(tx_pos_q - 10'd5);

	always_comb begin
		phase_d      = phase_q;
		tx_pos_d     = tx_pos_q;
		rx_pos_d     = rx_pos_q;
		bound_d      = bound_q;
		reply_byte_d = reply_byte_q;
		reply_seen_d = reply_seen_q;
		txv          = 1'b0;
		txl          = 1'b0;
		const_byte   = '0;
		sel          = SEL_CONST;
		rd_idx       = '0;
		msg_len      = host_end + 10'd2;

		case (q_cmd.op)
			OP_START: begin
				tx_pos_d     = '0;
				rx_pos_d     = '0;
				bound_d      = '0;
				reply_byte_d = '0;
				reply_seen_d = 1'b0;
				phase_d      = (host_len_q == '0) ? PH_ERR_HOST : PH_GREET_TX;
			end
			OP_PULL: begin
				if (phase_q == PH_GREET_TX || phase_q == PH_AUTH_TX ||
				    phase_q == PH_REQ_TX) begin
					txv = 1'b1;
					if (phase_q == PH_GREET_TX) begin
						msg_len = use_auth_q ? 10'd4 : 10'd3;
						case (tx_pos_q)
							10'd0:   const_byte = SOCKS_VER;
							10'd1:   const_byte = use_auth_q ? 8'd2 : 8'd1;
							10'd2:   const_byte = METHOD_NONE;
							10'd3:   const_byte = METHOD_USERPASS;
							default: const_byte = '0;
						endcase
					end else if (phase_q == PH_AUTH_TX) begin
						msg_len = auth_len;
						if (tx_pos_q == 10'd0) begin
							const_byte = AUTH_VER;
						end else if (tx_pos_q == 10'd1) begin
							const_byte = user_len_q;
						end else if (tx_pos_q < user_end) begin
							rd_idx = user_idx;
							if (idx_in_range(user_idx)) sel = SEL_USER;
						end else if (tx_pos_q == user_end) begin
							const_byte = pass_len_q;
						end else if (tx_pos_q < auth_len) begin
							rd_idx = pass_idx;
							if (idx_in_range(pass_idx)) sel = SEL_PASS;
						end
					end else begin
						case (tx_pos_q)
							10'd0: const_byte = SOCKS_VER;
							10'd1: const_byte = CMD_CONNECT;
							10'd2: const_byte = 8'd0;
							10'd3: const_byte = ATYP_DOMAIN;
							10'd4: const_byte = host_len_q;
							default: begin
								if (tx_pos_q < host_end) begin
									rd_idx = host_idx;
									if (idx_in_range(host_idx)) sel = SEL_HOST;
								end else if (tx_pos_q == host_end) begin
									const_byte = tgt_port_q[15:8];
								end else if (tx_pos_q == host_end + 10'd1) begin
									const_byte = tgt_port_q[7:0];
								end
							end
						endcase
					end
					if ({1'b0, tx_pos_q} + 11'd1 >= {1'b0, msg_len}) begin
						txl      = 1'b1;
						tx_pos_d = '0;
						rx_pos_d = '0;
						if (phase_q == PH_GREET_TX) phase_d = PH_GREET_RX;
						else if (phase_q == PH_AUTH_TX) phase_d = PH_AUTH_RX;
						else phase_d = PH_REP_RX;
					end else begin
						tx_pos_d = tx_pos_q + 10'd1;
					end
				end
			end
			OP_RX: begin
				case (phase_q)
					PH_GREET_RX: begin
						if (rx_pos_q == 2'd0) begin
							if (q_cmd.value != SOCKS_VER) phase_d = PH_ERR_PROTO;
							else rx_pos_d = 2'd1;
						end else if (q_cmd.value == METHOD_USERPASS && use_auth_q) begin
							phase_d  = PH_AUTH_TX;
							tx_pos_d = '0;
						end else if (q_cmd.value == METHOD_NONE) begin
							phase_d  = PH_REQ_TX;
							tx_pos_d = '0;
						end else begin
							phase_d = PH_ERR_PROTO;
						end
					end
					PH_AUTH_RX: begin
						if (rx_pos_q == 2'd0) begin
							if (q_cmd.value != AUTH_VER) phase_d = PH_ERR_AUTH;
							else rx_pos_d = 2'd1;
						end else if (q_cmd.value != 8'd0) begin
							phase_d = PH_ERR_AUTH;
						end else begin
							phase_d  = PH_REQ_TX;
							tx_pos_d = '0;
						end
					end
					PH_REP_RX: begin
						case (rx_pos_q)
							2'd0: begin
								if (q_cmd.value != SOCKS_VER) phase_d = PH_ERR_PROTO;
								else rx_pos_d = 2'd1;
							end
							2'd1: begin
								reply_byte_d = q_cmd.value;
								reply_seen_d = 1'b1;
								if (q_cmd.value != REP_OK) phase_d = PH_ERR_REFUSED;
								else rx_pos_d = 2'd2;
							end
							2'd2: rx_pos_d = 2'd3;
							default: begin
								// address type picks how many bound bytes follow
								if (q_cmd.value == ATYP_IPV4) begin
									bound_d = IPV4_BOUND;
									phase_d = PH_BOUND_RX;
								end else if (q_cmd.value == ATYP_IPV6) begin
									bound_d = IPV6_BOUND;
									phase_d = PH_BOUND_RX;
								end else if (q_cmd.value == ATYP_DOMAIN) begin
									phase_d = PH_REP_LEN;
								end else begin
									phase_d = PH_ERR_PROTO;
								end
							end
						endcase
					end
					PH_REP_LEN: begin
						bound_d = 9'(q_cmd.value) + 9'd2;
						phase_d = PH_BOUND_RX;
					end
					PH_BOUND_RX: begin
						if (bound_q != '0) bound_d = bound_q - 9'd1;
						if (bound_d == '0) phase_d = PH_DONE;
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		case (phase_d)
			PH_DONE:        status_d = STATUS_CONNECTED;
			PH_ERR_HOST:    status_d = STATUS_BAD_HOST;
			PH_ERR_PROTO:   status_d = STATUS_PROTO;
			PH_ERR_AUTH:    status_d = STATUS_AUTH;
			PH_ERR_REFUSED: status_d = STATUS_REFUSED;
			default:        status_d = STATUS_BUSY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			tx_pos_q       <= '0;
			rx_pos_q       <= '0;
			bound_q        <= '0;
			reply_byte_q   <= '0;
			reply_seen_q   <= 1'b0;
			out_valid_s2   <= 1'b0;
			tx_valid_s2    <= 1'b0;
			tx_last_s2     <= 1'b0;
			const_s2       <= '0;
			sel_s2         <= SEL_CONST;
			status_s2      <= STATUS_BUSY;
			reply_valid_s2 <= 1'b0;
			reply_code_s2  <= '0;
		end else if (fire) begin
			phase_q        <= phase_d;
			tx_pos_q       <= tx_pos_d;
			rx_pos_q       <= rx_pos_d;
			bound_q        <= bound_d;
			reply_byte_q   <= reply_byte_d;
			reply_seen_q   <= reply_seen_d;
			out_valid_s2   <= 1'b1;
			tx_valid_s2    <= txv;
			tx_last_s2     <= txl;
			const_s2       <= const_byte;
			sel_s2         <= sel;
			status_s2      <= status_d;
			reply_valid_s2 <= reply_seen_d;
			reply_code_s2  <= reply_seen_d ? reply_byte_d : 8'd0;
		end else if (rsp.ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	// read data only moves on fire, so it stays aligned with the result register
	always_ff @(posedge clk) begin
		if (fire && q_cmd.op == OP_LOAD_HOST && wr_ok)
			host_mem[q_cmd.index[STORE_AW-1:0]] <= q_cmd.value;
		if (fire)
			host_rd_s2 <= host_mem[rd_idx[STORE_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (fire && q_cmd.op == OP_LOAD_USER && wr_ok)
			user_mem[q_cmd.index[STORE_AW-1:0]] <= q_cmd.value;
		if (fire)
			user_rd_s2 <= user_mem[rd_idx[STORE_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (fire && q_cmd.op == OP_LOAD_PASS && wr_ok)
			pass_mem[q_cmd.index[STORE_AW-1:0]] <= q_cmd.value;
		if (fire)
			pass_rd_s2 <= pass_mem[rd_idx[STORE_AW-1:0]];
	end

	always_comb begin
		case (sel_s2)
			SEL_HOST: rsp.tx_byte = host_rd_s2;
			SEL_USER: rsp.tx_byte = user_rd_s2;
			SEL_PASS: rsp.tx_byte = pass_rd_s2;
			default:  rsp.tx_byte = const_s2;
		endcase
	end

	assign rsp.valid       = out_valid_s2;
	assign rsp.tx_valid    = tx_valid_s2;
	assign rsp.tx_last     = tx_last_s2;
	assign rsp.status      = status_s2;
	assign rsp.reply_valid = reply_valid_s2;
	assign rsp.reply_code  = reply_code_s2;

`ifndef SYNTHESIS
	a_terminal_holds: assert property (@(posedge clk) disable iff (!arst_n)
		((phase_q == PH_DONE || phase_q == PH_ERR_HOST || phase_q == PH_ERR_PROTO ||
		  phase_q == PH_ERR_AUTH || phase_q == PH_ERR_REFUSED) &&
		 !(fire && q_cmd.op == OP_START)) |=> phase_q == $past(phase_q))
		else $error("terminal phase left without a start");

	a_tx_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && tx_valid_s2) |-> status_s2 == STATUS_BUSY)
		else $error("transmit byte reported with a final status");

	a_last_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && tx_last_s2) |-> tx_valid_s2)
		else $error("message end flagged without a transmit byte");
`endif

endmodule

// ===== design/socks5_client_handshake.sv =====
`timescale 1ns / 1ps
// The front queue registers each accepted transaction, then the execute stage registers its result.
// Throughput: one input transaction per cycle sustained while rsp.ready holds; the handshake
// state update and store read close in a single execute stage, fed by a 2-entry queue.
// Reset: arst_n clears the phase, positions, reply, queue and configuration;
// the host, user and password stores stay undefined until loaded, no clearing pass.
// ----------------------------------------------------------------------------
// socks5_client_handshake
// Client side of the SOCKS5 CONNECT handshake with user/password auth.
// ----------------------------------------------------------------------------
module socks5_client_handshake
	import s5hs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	s5hs_in_if.sink               req,
	s5hs_out_if.source            rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic q_valid;
	logic q_ready;
	cmd_t q_cmd;

	s5hs_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_cmd   (q_cmd)
	);

	s5hs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_cmd     (q_cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp       (rsp)
	);

endmodule
